// ===== hw/rtl/rca_pkg.sv =====
`default_nettype none
package rca_pkg;
    localparam int DataWidthDefault = 32;
    localparam int OpcodeWidth = 4;
    localparam int ErrorWidth = 3;

    localparam logic [OpcodeWidth-1:0] OpAdd  = 4'd0;
    localparam logic [OpcodeWidth-1:0] OpSub  = 4'd1;
    localparam logic [OpcodeWidth-1:0] OpMul  = 4'd2;
    localparam logic [OpcodeWidth-1:0] OpDiv  = 4'd3;
    localparam logic [OpcodeWidth-1:0] OpPow  = 4'd4;
    localparam logic [OpcodeWidth-1:0] OpFact = 4'd5;
    localparam logic [OpcodeWidth-1:0] OpMax  = 4'd6;
    localparam logic [OpcodeWidth-1:0] OpMin  = 4'd7;

    localparam logic [ErrorWidth-1:0] ErrNone     = 3'd0;
    localparam logic [ErrorWidth-1:0] ErrDivZero  = 3'd1;
    localparam logic [ErrorWidth-1:0] ErrDivOvf   = 3'd2;
    localparam logic [ErrorWidth-1:0] ErrNegFact  = 3'd3;
    localparam logic [ErrorWidth-1:0] ErrBadCount = 3'd4;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_PUSH_PREV,
        CMD_PUSH_IN,
        CMD_STEP
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        logic    start;
        logic    finish;
    } t_cmd;

    typedef struct packed {
        logic need_iter;
        logic iter_done;
    } t_status;
endpackage
`default_nettype wire

// ===== hw/rtl/reduction_calculator_alu.sv =====
// Add, sub, mul, max, min, recall and any run that needs no iteration
// (errors, negative exponent, factorial of 66 or more) go straight from
// the last word to the result; divide, power and factorial of 0 to 65
// step through the shared iterative unit first. A first word with
// use_previous also pushes the previous result ahead of it. Synchronous
// active-low reset clears run state and valid.
`default_nettype none
module reduction_calculator_alu #(
    parameter int DATA_WIDTH = rca_pkg::DataWidthDefault
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire [3:0]  i_opcode,
    input  wire [DATA_WIDTH-1:0] i_operand,
    input  wire        i_use_previous,
    input  wire        i_last,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic [2:0] o_error
);
    rca_pkg::t_cmd    w_cmd;
    rca_pkg::t_status w_status;
    logic             w_capture;
    logic [DATA_WIDTH-1:0] w_value;
    logic [2:0]       w_error;
    logic [DATA_WIDTH-1:0] r_operand;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_operand <= i_operand;
        if (w_capture) begin
            o_value <= w_value;
            o_error <= w_error;
        end
    end

    rca_control u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_use_previous(i_use_previous), .i_last(i_last),
        .i_status(w_status), .o_cmd(w_cmd), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .o_capture(w_capture)
    );

    rca_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_opcode(i_opcode),
        .i_operand((w_cmd.op == rca_pkg::CMD_PUSH_IN && !w_cmd.start
            && !(i_in_valid && o_in_ready)) ? r_operand : i_operand),
        .o_status(w_status), .o_value(w_value), .o_error(w_error)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/rca_datapath.sv =====
`default_nettype none
module rca_datapath #(
    parameter int DATA_WIDTH = rca_pkg::DataWidthDefault
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire rca_pkg::t_cmd            i_cmd,
    input  wire [rca_pkg::OpcodeWidth-1:0] i_opcode,
    input  wire [DATA_WIDTH-1:0]          i_operand,
    output rca_pkg::t_status              o_status,
    output logic [DATA_WIDTH-1:0]         o_value,
    output logic [rca_pkg::ErrorWidth-1:0] o_error
);
    localparam int W = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] SignW = {1'b1, {(W-1){1'b0}}};
    localparam int FactLimit = 2 * W + 2;

    logic [W-1:0] r_acc, r_first, r_prev;
    logic [1:0]   r_count;
    logic [rca_pkg::OpcodeWidth-1:0] r_op;

    logic [W-1:0] r_a, r_b, r_r;
    logic [CW-1:0] r_iter;
    logic          r_neg;
    logic          r_busy;

    logic [W-1:0] w_x, w_a_next, w_rem_sh, w_sub;
    logic [W-1:0] w_mul;
    logic [W-1:0] w_val;
    logic [rca_pkg::OpcodeWidth-1:0] w_op;
    logic [1:0]   w_cnt;
    logic         w_kind_div, w_kind_pow, w_kind_fact;

    function automatic logic s_lt(input logic [W-1:0] a, input logic [W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    always_comb begin
        w_x = (i_cmd.op == rca_pkg::CMD_PUSH_PREV) ? r_prev : i_operand;
        w_op = i_cmd.start ? i_opcode : r_op;
        w_cnt = i_cmd.start ? 2'd0 : r_count;
        w_a_next = r_acc;
        unique case (w_op)
            rca_pkg::OpAdd: w_a_next = (w_cnt == 2'd0) ? w_x : r_acc + w_x;
            rca_pkg::OpSub: w_a_next = (w_cnt == 2'd0) ? w_x : r_acc - w_x;
            rca_pkg::OpMul: w_a_next = (w_cnt == 2'd0) ? w_x : W'(r_acc * w_x);
            rca_pkg::OpMax: if (w_cnt == 2'd0 || s_lt(r_acc, w_x)) w_a_next = w_x;
            rca_pkg::OpMin: if (w_cnt == 2'd0 || s_lt(w_x, r_acc)) w_a_next = w_x;
            rca_pkg::OpDiv, rca_pkg::OpPow, rca_pkg::OpFact:
                if (w_cnt == 2'd1) w_a_next = w_x;
            default: w_a_next = r_acc;
        endcase
        w_kind_div = (r_op == rca_pkg::OpDiv);
        w_kind_pow = (r_op == rca_pkg::OpPow);
        w_kind_fact = (r_op == rca_pkg::OpFact);
        w_mul = W'(r_r * (w_kind_fact ? r_a : r_b));
        w_rem_sh = {r_r[W-2:0], r_a[W-1]};
        w_sub = w_rem_sh - r_b;
    end

    logic w_need;
    always_comb begin
        w_need = 1'b0;
        if (w_kind_div) w_need = (r_count == 2'd2) && (r_acc != '0)
            && !(r_first == SignW && r_acc == '1);
        if (w_kind_pow) w_need = (r_count == 2'd2) && !r_acc[W-1];
        if (w_kind_fact) w_need = !r_first[W-1] && (r_first < W'(FactLimit));
    end
    assign o_status = '{need_iter: w_need, iter_done: r_busy && (r_iter == '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_first <= '0;
            r_count <= 2'd0;
            r_prev <= '0;
            r_op <= '0;
            r_busy <= 1'b0;
            r_iter <= '0;
        end else begin
            if (i_cmd.op == rca_pkg::CMD_PUSH_PREV || i_cmd.op == rca_pkg::CMD_PUSH_IN) begin
                r_op <= w_op;
                r_acc <= w_a_next;
                if (w_cnt == 2'd0 && (w_op == rca_pkg::OpDiv || w_op == rca_pkg::OpPow
                        || w_op == rca_pkg::OpFact)) r_first <= w_x;
                r_count <= (w_cnt == 2'd3) ? 2'd3 : w_cnt + 2'd1;
            end
            if (i_cmd.op == rca_pkg::CMD_STEP) begin
                if (!r_busy) begin
                    r_busy <= 1'b1;
                    r_iter <= CW'(W);
                    r_neg <= r_first[W-1] ^ r_acc[W-1];
                    if (w_kind_div) begin
                        r_a <= r_first[W-1] ? -r_first : r_first;
                        r_b <= r_acc[W-1] ? -r_acc : r_acc;
                        r_r <= '0;
                    end else if (w_kind_pow) begin
                        r_a <= r_acc;
                        r_b <= r_first;
                        r_r <= W'(1);
                    end else begin
                        r_a <= W'(2);
                        r_b <= r_first;
                        r_r <= W'(1);
                    end
                end else if (r_iter != '0) begin
                    r_iter <= r_iter - CW'(1);
                    if (w_kind_div) begin
                        if (w_rem_sh >= r_b) r_r <= w_sub;
                        else r_r <= w_rem_sh;
                        r_a <= {r_a[W-2:0], (w_rem_sh >= r_b)};
                    end else if (w_kind_pow) begin
                        if (r_a[0]) r_r <= w_mul;
                        r_b <= W'(r_b * r_b);
                        r_a <= r_a >> 1;
                    end else begin
                        if (r_a <= r_b) r_r <= w_mul;
                        if (r_a <= r_b) r_a <= r_a + W'(1);
                        if (r_iter > CW'(1) && r_a + W'(1) <= r_b) r_iter <= CW'(2);
                    end
                end
            end
            if (i_cmd.finish) begin
                r_count <= 2'd0;
                r_busy <= 1'b0;
                if (r_op <= rca_pkg::OpMin && o_error == rca_pkg::ErrNone)
                    r_prev <= w_val;
            end
        end
    end

    always_comb begin
        o_error = rca_pkg::ErrNone;
        w_val = '0;
        if (r_op > rca_pkg::OpMin) w_val = r_prev;
        else if (w_kind_div) begin
            if (r_count != 2'd2) o_error = rca_pkg::ErrBadCount;
            else if (r_acc == '0) o_error = rca_pkg::ErrDivZero;
            else if (r_first == SignW && r_acc == '1) o_error = rca_pkg::ErrDivOvf;
            else w_val = r_neg ? -r_a : r_a;
        end else if (w_kind_pow) begin
            if (r_count != 2'd2) o_error = rca_pkg::ErrBadCount;
            else if (w_need) w_val = r_r;
        end else if (w_kind_fact) begin
            if (r_first[W-1]) o_error = rca_pkg::ErrNegFact;
            else if (w_need) w_val = r_r;
        end else w_val = r_acc;
        o_value = w_val;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rca_control.sv =====
`default_nettype none
module rca_control (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire                i_use_previous,
    input  wire                i_last,
    input  wire rca_pkg::t_status i_status,
    output rca_pkg::t_cmd      o_cmd,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic               o_capture
);
    typedef enum logic [2:0] {S_FIRST, S_MORE, S_PREV, S_EVAL, S_ITER, S_DONE} t_state;
    t_state r_state, n_state;
    logic   r_last, r_valid;

    assign o_in_ready = (r_state == S_FIRST || r_state == S_MORE);
    assign o_out_valid = r_valid;

    always_comb begin
        o_cmd = '{op: rca_pkg::CMD_NONE, start: 1'b0, finish: 1'b0};
        o_capture = 1'b0;
        n_state = r_state;
        unique case (r_state)
            S_FIRST, S_MORE: if (i_in_valid && o_in_ready) begin
                o_cmd.start = (r_state == S_FIRST);
                if (r_state == S_FIRST && i_use_previous) begin
                    o_cmd.op = rca_pkg::CMD_PUSH_PREV;
                    n_state = S_PREV;
                end else begin
                    o_cmd.op = rca_pkg::CMD_PUSH_IN;
                    n_state = i_last ? S_EVAL : S_MORE;
                end
            end
            S_PREV: begin
                o_cmd.op = rca_pkg::CMD_PUSH_IN;
                n_state = r_last ? S_EVAL : S_MORE;
            end
            S_EVAL: begin
                if (i_status.need_iter) begin
                    o_cmd.op = rca_pkg::CMD_STEP;
                    n_state = S_ITER;
                end else n_state = S_DONE;
            end
            S_ITER: begin
                o_cmd.op = rca_pkg::CMD_STEP;
                if (i_status.iter_done) n_state = S_DONE;
            end
            S_DONE: if (!r_valid || i_out_ready) begin
                o_capture = 1'b1;
                o_cmd.finish = 1'b1;
                n_state = S_FIRST;
            end
            default: n_state = S_FIRST;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FIRST;
            r_last <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_in_valid && o_in_ready) r_last <= i_last;
            if (o_capture) r_valid <= 1'b1;
            else if (i_out_ready) r_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== tb/reduction_calculator_alu_checker.sv =====
`timescale 1ns / 100ps
module reduction_calculator_alu_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  wire [3:0]  i_opcode,
    input  wire [31:0] i_operand,
    input  wire        i_use_previous,
    input  wire        i_last,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  wire [31:0] i_value,
    input  wire [2:0]  i_error,
    output int         o_fail_count,
    output int         o_pending
);
    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  error;
    } t_run_result;

    t_run_result expected_results[$];

    logic [31:0] acc_q;
    logic [31:0] first_q;
    logic [1:0]  count_q;
    logic [31:0] prev_q;
    logic [3:0]  run_op_q;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic push_element(input logic [31:0] x);
        case (run_op_q)
            rca_pkg::OpAdd: acc_q = (count_q == 2'd0) ? x : acc_q + x;
            rca_pkg::OpSub: acc_q = (count_q == 2'd0) ? x : acc_q - x;
            rca_pkg::OpMul: acc_q = (count_q == 2'd0) ? x : acc_q * x;
            rca_pkg::OpMax: if (count_q == 2'd0 || $signed(acc_q) < $signed(x)) acc_q = x;
            rca_pkg::OpMin: if (count_q == 2'd0 || $signed(x) < $signed(acc_q)) acc_q = x;
            rca_pkg::OpDiv, rca_pkg::OpPow, rca_pkg::OpFact: begin
                if (count_q == 2'd0) first_q = x;
                else if (count_q == 2'd1) acc_q = x;
            end
            default: ;
        endcase
        count_q = (count_q < 2'd3) ? count_q + 2'd1 : 2'd3;
    endtask

    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] power(input logic [31:0] base, input logic [31:0] e);
        logic [31:0] r;
        logic [31:0] b;
        r = 32'd1;
        b = base;
        if (e[31]) return 32'd0;
        for (int i = 0; i < 31; i++) begin
            if (e[i]) r = r * b;
            b = b * b;
        end
        return r;
    endfunction

    function automatic logic [31:0] factorial(input logic [31:0] n);
        logic [31:0] r;
        r = 32'd1;
        if (n >= 32'd66) return 32'd0;
        for (int i = 2; i <= n; i++) r = r * 32'(i);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_run_result res;
        t_run_result exp_res;
        logic keep;
        if (!i_rst_n) begin
            acc_q = '0;
            first_q = '0;
            count_q = '0;
            prev_q = '0;
            run_op_q = '0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (count_q == 2'd0) begin
                    run_op_q = i_opcode;
                    if (i_use_previous) push_element(prev_q);
                end
                push_element(i_operand);
                if (i_last) begin
                    res.value = '0;
                    res.error = rca_pkg::ErrNone;
                    keep = 1'b0;
                    case (run_op_q)
                        rca_pkg::OpAdd, rca_pkg::OpSub, rca_pkg::OpMul,
                        rca_pkg::OpMax, rca_pkg::OpMin: res.value = acc_q;
                        rca_pkg::OpDiv: begin
                            if (count_q != 2'd2) res.error = rca_pkg::ErrBadCount;
                            else if (acc_q == 32'd0) res.error = rca_pkg::ErrDivZero;
                            else if (first_q == 32'h8000_0000 && acc_q == 32'hFFFF_FFFF)
                                res.error = rca_pkg::ErrDivOvf;
                            else res.value = div_trunc(first_q, acc_q);
                        end
                        rca_pkg::OpPow: begin
                            if (count_q != 2'd2) res.error = rca_pkg::ErrBadCount;
                            else res.value = power(first_q, acc_q);
                        end
                        rca_pkg::OpFact: begin
                            if (first_q[31]) res.error = rca_pkg::ErrNegFact;
                            else res.value = factorial(first_q);
                        end
                        default: begin
                            res.value = prev_q;
                            keep = 1'b1;
                        end
                    endcase
                    if (res.error != rca_pkg::ErrNone) res.value = '0;
                    else if (!keep) prev_q = res.value;
                    count_q = '0;
                    expected_results.push_back(res);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word value=%h error=%0d",
                             $time, i_value, i_error);
                    o_fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_value !== exp_res.value) begin
                        $display("%0t: value expected %h actual %h",
                                 $time, exp_res.value, i_value);
                        o_fail_count++;
                    end
                    if (i_error !== exp_res.error) begin
                        $display("%0t: error expected %0d actual %0d",
                                 $time, exp_res.error, i_error);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule

// ===== tb/reduction_calculator_alu_tb.sv =====
`timescale 1ns / 100ps
module reduction_calculator_alu_tb;
    localparam logic [3:0] OpRecall = 4'd8;
    localparam logic [3:0] OpUnused = 4'd15;
    localparam int WatchdogLimit = 5000;
    localparam int HoldCycles = 300;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [3:0]  opcode = 0;
    logic [31:0] operand = 0;
    logic        use_previous = 0;
    logic        last = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [31:0] value;
    logic [2:0]  error;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_req = 0;
    logic        held = 0;
    int          idle_cycles = 0;

    always #10 clk = ~clk;

    reduction_calculator_alu DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_opcode(opcode), .i_operand(operand),
        .i_use_previous(use_previous), .i_last(last),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_value(value), .o_error(error)
    );

    reduction_calculator_alu_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_opcode(opcode), .i_operand(operand),
        .i_use_previous(use_previous), .i_last(last),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_value(value), .i_error(error),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        if (hold_req && !held) begin
            out_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clk);
            held = 1'b1;
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input logic [3:0] op, input logic [31:0] x,
                             input logic up, input logic lst);
        logic taken;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        operand <= x;
        use_previous <= up;
        last <= lst;
        do begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2, 3: return $urandom_range(16) - 8;
            4: return $urandom_range(300);
            default: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'd0;
                endcase
            end
        endcase
    endfunction

    task automatic send_random_run(output int run_words);
        logic [3:0]  op;
        logic        up;
        int          len;
        logic [31:0] x;
        op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        up = ($urandom_range(3) == 0);
        len = $urandom_range(4, 1);
        if (op == rca_pkg::OpDiv || op == rca_pkg::OpPow) begin
            if ($urandom_range(9) != 0) len = up ? 1 : 2;
        end
        for (int i = 0; i < len; i++) begin
            x = rand_operand();
            if (op == rca_pkg::OpFact && i == 0 && !up && $urandom_range(3) != 0)
                x = $urandom_range(70);
            if (op == rca_pkg::OpPow && $urandom_range(2) != 0)
                x = (i == len - 1) ? 32'($urandom_range(40)) : x;
            send_word(op, x, (i == 0) ? up : 1'($urandom_range(1)), i == len - 1);
        end
        run_words = len;
    endtask

    initial begin
        int sent;
        int run_words;
        int idle_set[4];
        int stall_set[4];
        idle_set = '{0, 56, 0, 32};
        stall_set = '{0, 0, 56, 32};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(rca_pkg::OpAdd, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_word(rca_pkg::OpAdd, 32'd1, 1'b0, 1'b1);
        send_word(rca_pkg::OpSub, 32'h8000_0000, 1'b0, 1'b0);
        send_word(rca_pkg::OpSub, 32'd1, 1'b0, 1'b1);
        send_word(rca_pkg::OpMul, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_word(rca_pkg::OpMul, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(rca_pkg::OpMax, 32'h8000_0000, 1'b0, 1'b0);
        send_word(rca_pkg::OpMax, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(rca_pkg::OpMin, 32'h7FFF_FFFF, 1'b0, 1'b1);
        send_word(rca_pkg::OpDiv, 32'd7, 1'b0, 1'b0);
        send_word(rca_pkg::OpDiv, 32'd0, 1'b0, 1'b1);
        send_word(rca_pkg::OpDiv, 32'h8000_0000, 1'b0, 1'b0);
        send_word(rca_pkg::OpDiv, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(rca_pkg::OpDiv, 32'hFFFF_FFF9, 1'b1, 1'b1);
        send_word(rca_pkg::OpDiv, 32'd9, 1'b0, 1'b1);
        send_word(rca_pkg::OpPow, 32'd0, 1'b0, 1'b0);
        send_word(rca_pkg::OpPow, 32'd0, 1'b0, 1'b1);
        send_word(rca_pkg::OpPow, 32'd3, 1'b0, 1'b0);
        send_word(rca_pkg::OpPow, 32'hFFFF_FFFE, 1'b0, 1'b1);
        send_word(rca_pkg::OpFact, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(rca_pkg::OpFact, 32'd0, 1'b0, 1'b1);
        send_word(rca_pkg::OpFact, 32'd34, 1'b0, 1'b1);
        send_word(rca_pkg::OpFact, 32'd12, 1'b0, 1'b0);
        send_word(rca_pkg::OpFact, 32'd99, 1'b0, 1'b1);
        send_word(OpRecall, 32'd5, 1'b0, 1'b1);
        send_word(OpUnused, 32'd5, 1'b1, 1'b1);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            sent = 0;
            while (sent < 280) begin
                if (p == 0 && sent >= 40) hold_req <= 1'b1;
                send_random_run(run_words);
                sent += run_words;
            end
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
